[rtl/core/cpc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types and constants for the circle pair contact pipeline.
// ----------------------------------------------------------------------------
package cpc_pkg;

  // Rounding offset for a Q1.30 product: one half of an LSB after the shift
  localparam logic [31:0] Q30Half  = 32'h2000_0000;
  localparam int unsigned Q30Shift = 30;

  // Saturation limits of the contact point and the separation
  localparam logic [31:0] PointMax = 32'h7FFF_FFFF;
  localparam logic [31:0] PointMin = 32'h8000_0000;
  localparam logic [33:0] SepMax   = 34'h1_FFFF_FFFF;
  localparam logic [33:0] SepMin   = 34'h2_0000_0000;

  // Per-item data that travels beside the root and divide stages
  typedef struct packed {
    logic               contact;
    logic               neg_x;
    logic               neg_y;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic        [30:0] ra;
    logic        [30:0] rb;
    logic        [30:0] mx;
    logic        [30:0] my;
  } cpc_side_t;

endpackage
`default_nettype wire

[rtl/core/cpc_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_ifs
// Valid/ready channels for circle pairs in and contact results out.
// ----------------------------------------------------------------------------
interface cpc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic        [30:0] a_radius;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic        [30:0] b_radius;

  modport source (output valid, a_x, a_y, a_radius, b_x, b_y, b_radius, input ready);
  modport sink   (input valid, a_x, a_y, a_radius, b_x, b_y, b_radius, output ready);
endinterface

interface cpc_out_if;
  logic               valid;
  logic               ready;
  logic               has_contact;
  logic signed [31:0] normal_x;
  logic signed [31:0] normal_y;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [33:0] separation;

  modport source (output valid, has_contact, normal_x, normal_y, point_x, point_y,
                  separation, input ready);
  modport sink   (input valid, has_contact, normal_x, normal_y, point_x, point_y,
                  separation, output ready);
endinterface
`default_nettype wire

[rtl/core/circle_pair_contact_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// circle_pair_contact_core
// Box overlap, distance gate, unit normal, contact point and separation for
// one pair of circles per cycle.
// ----------------------------------------------------------------------------
// Stages from input transfer to the result on the output register:
//   3 setup stages, 32 square root stages, 32 divide stages, 6 product stages.
// Throughput: one pair per cycle; the whole pipe holds only while the output
//   register has a result that is not taken.
// Reset: valid bits clear, min_distance returns to 1; data registers keep.
module circle_pair_contact_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  cpc_in_if.sink      in_if,
  cpc_out_if.source   out_if
);

  // pipeline advance: all stages move together unless the result is stuck
  logic adv;
  logic m6_v_q;
  assign adv         = !m6_v_q || out_if.ready;
  assign in_if.ready = adv;

  // configuration register
  logic [15:0] md_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q <= 16'd1;
    end else if (cfg_we_i) begin
      md_q <= cfg_wdata_i;
    end
  end

  // ---------------- E1: box test, centre difference ----------------
  logic signed [33:0] ax_w, ay_w, bx_w, by_w, ra_w, rb_w;
  logic signed [32:0] dx_w, dy_w;
  logic        [32:0] mx_w, my_w;
  logic               ovl_w;

  assign ax_w = {{2{in_if.a_x[31]}}, in_if.a_x};
  assign ay_w = {{2{in_if.a_y[31]}}, in_if.a_y};
  assign bx_w = {{2{in_if.b_x[31]}}, in_if.b_x};
  assign by_w = {{2{in_if.b_y[31]}}, in_if.b_y};
  assign ra_w = {3'b000, in_if.a_radius};
  assign rb_w = {3'b000, in_if.b_radius};

  assign ovl_w = (bx_w - rb_w <= ax_w + ra_w) && (ax_w - ra_w <= bx_w + rb_w) &&
                 (by_w - rb_w <= ay_w + ra_w) && (ay_w - ra_w <= by_w + rb_w);

  assign dx_w = {in_if.b_x[31], in_if.b_x} - {in_if.a_x[31], in_if.a_x};
  assign dy_w = {in_if.b_y[31], in_if.b_y} - {in_if.a_y[31], in_if.a_y};
  assign mx_w = dx_w[32] ? 33'(-dx_w) : dx_w;
  assign my_w = dy_w[32] ? 33'(-dy_w) : dy_w;

  logic               e1_v_q, e1_ovl_q, e1_negx_q, e1_negy_q;
  logic        [32:0] e1_mx_q, e1_my_q;
  logic signed [31:0] e1_ax_q, e1_ay_q, e1_bx_q, e1_by_q;
  logic        [30:0] e1_ra_q, e1_rb_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_ovl_q  <= ovl_w;
      e1_negx_q <= dx_w[32];
      e1_negy_q <= dy_w[32];
      e1_mx_q   <= mx_w;
      e1_my_q   <= my_w;
      e1_ax_q   <= in_if.a_x;
      e1_ay_q   <= in_if.a_y;
      e1_bx_q   <= in_if.b_x;
      e1_by_q   <= in_if.b_y;
      e1_ra_q   <= in_if.a_radius;
      e1_rb_q   <= in_if.b_radius;
    end
  end

  // ---------------- E2: distance gate, range shift, squares ----------------
  logic        big_w, small_w, near_w;
  logic [30:0] mxs_w, mys_w;
  logic [31:0] nsqx_w, nsqy_w;
  logic [32:0] nsum_w;
  logic [31:0] md2_w;
  logic [61:0] sqx_w, sqy_w;

  assign big_w   = |{e1_mx_q[32:31], e1_my_q[32:31]};
  assign mxs_w   = big_w ? e1_mx_q[31:1] : e1_mx_q[30:0];
  assign mys_w   = big_w ? e1_my_q[31:1] : e1_my_q[30:0];
  assign small_w = ~|e1_mx_q[32:16] && ~|e1_my_q[32:16];
  assign nsqx_w  = e1_mx_q[15:0] * e1_mx_q[15:0];
  assign nsqy_w  = e1_my_q[15:0] * e1_my_q[15:0];
  assign nsum_w  = {1'b0, nsqx_w} + {1'b0, nsqy_w};
  assign md2_w   = md_q * md_q;
  assign near_w  = small_w && (nsum_w < {1'b0, md2_w});
  assign sqx_w   = mxs_w * mxs_w;
  assign sqy_w   = mys_w * mys_w;

  logic               e2_v_q, e2_contact_q, e2_negx_q, e2_negy_q;
  logic        [61:0] e2_sqx_q, e2_sqy_q;
  logic        [30:0] e2_mx_q, e2_my_q;
  logic signed [31:0] e2_ax_q, e2_ay_q, e2_bx_q, e2_by_q;
  logic        [30:0] e2_ra_q, e2_rb_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e2_contact_q <= e1_ovl_q && !near_w;
      e2_negx_q    <= e1_negx_q;
      e2_negy_q    <= e1_negy_q;
      e2_sqx_q     <= sqx_w;
      e2_sqy_q     <= sqy_w;
      e2_mx_q      <= mxs_w;
      e2_my_q      <= mys_w;
      e2_ax_q      <= e1_ax_q;
      e2_ay_q      <= e1_ay_q;
      e2_bx_q      <= e1_bx_q;
      e2_by_q      <= e1_by_q;
      e2_ra_q      <= e1_ra_q;
      e2_rb_q      <= e1_rb_q;
    end
  end

  // ---------------- E3: sum of squares ----------------
  logic               e3_v_q;
  logic [62:0]        e3_sum_q;
  cpc_pkg::cpc_side_t e3_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e3_sum_q          <= {1'b0, e2_sqx_q} + {1'b0, e2_sqy_q};
      e3_side_q.contact <= e2_contact_q;
      e3_side_q.neg_x   <= e2_negx_q;
      e3_side_q.neg_y   <= e2_negy_q;
      e3_side_q.ax      <= e2_ax_q;
      e3_side_q.ay      <= e2_ay_q;
      e3_side_q.bx      <= e2_bx_q;
      e3_side_q.by      <= e2_by_q;
      e3_side_q.ra      <= e2_ra_q;
      e3_side_q.rb      <= e2_rb_q;
      e3_side_q.mx      <= e2_mx_q;
      e3_side_q.my      <= e2_my_q;
    end
  end

  // ---------------- length and normal ----------------
  logic               sq_v;
  logic [31:0]        sq_len;
  cpc_pkg::cpc_side_t sq_side;

  cpc_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (e3_v_q),
    .rad_i   ({1'b0, e3_sum_q}),
    .side_i  (e3_side_q),
    .valid_o (sq_v),
    .root_o  (sq_len),
    .side_o  (sq_side)
  );

  logic               dv_v;
  logic [30:0]        dv_qx, dv_qy;
  logic               dv_lz;
  cpc_pkg::cpc_side_t dv_side;

  cpc_ndiv u_ndiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_v),
    .len_i   (sq_len),
    .side_i  (sq_side),
    .valid_o (dv_v),
    .qx_o    (dv_qx),
    .qy_o    (dv_qy),
    .lzero_o (dv_lz),
    .side_o  (dv_side)
  );

  // ---------------- M1: radius times normal ----------------
  logic [30:0] nmx_w, nmy_w;
  assign nmx_w = dv_lz ? 31'd0 : dv_qx;
  assign nmy_w = dv_lz ? 31'd0 : dv_qy;

  logic               m1_v_q, m1_contact_q, m1_negx_q, m1_negy_q;
  logic        [61:0] m1_pax_q, m1_pay_q, m1_pbx_q, m1_pby_q;
  logic        [30:0] m1_nmx_q, m1_nmy_q;
  logic signed [31:0] m1_ax_q, m1_ay_q, m1_bx_q, m1_by_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_contact_q <= dv_side.contact;
      m1_negx_q    <= dv_side.neg_x;
      m1_negy_q    <= dv_side.neg_y;
      m1_pax_q     <= dv_side.ra * nmx_w;
      m1_pay_q     <= dv_side.ra * nmy_w;
      m1_pbx_q     <= dv_side.rb * nmx_w;
      m1_pby_q     <= dv_side.rb * nmy_w;
      m1_nmx_q     <= nmx_w;
      m1_nmy_q     <= nmy_w;
      m1_ax_q      <= dv_side.ax;
      m1_ay_q      <= dv_side.ay;
      m1_bx_q      <= dv_side.bx;
      m1_by_q      <= dv_side.by;
    end
  end

  // ---------------- M2: round, surface points ----------------
  logic [31:0]        qax_w, qay_w, qbx_w, qby_w;
  logic signed [33:0] sax_w, say_w, sbx_w, sby_w;

  assign qax_w = 32'((m1_pax_q + 62'(cpc_pkg::Q30Half)) >> cpc_pkg::Q30Shift);
  assign qay_w = 32'((m1_pay_q + 62'(cpc_pkg::Q30Half)) >> cpc_pkg::Q30Shift);
  assign qbx_w = 32'((m1_pbx_q + 62'(cpc_pkg::Q30Half)) >> cpc_pkg::Q30Shift);
  assign qby_w = 32'((m1_pby_q + 62'(cpc_pkg::Q30Half)) >> cpc_pkg::Q30Shift);
  assign sax_w = m1_negx_q ? -$signed({2'b00, qax_w}) : $signed({2'b00, qax_w});
  assign say_w = m1_negy_q ? -$signed({2'b00, qay_w}) : $signed({2'b00, qay_w});
  assign sbx_w = m1_negx_q ? -$signed({2'b00, qbx_w}) : $signed({2'b00, qbx_w});
  assign sby_w = m1_negy_q ? -$signed({2'b00, qby_w}) : $signed({2'b00, qby_w});

  logic               m2_v_q, m2_contact_q, m2_negx_q, m2_negy_q;
  logic signed [34:0] m2_cax_q, m2_cay_q, m2_cbx_q, m2_cby_q;
  logic        [30:0] m2_nmx_q, m2_nmy_q;
  logic signed [31:0] m2_nx_q, m2_ny_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_contact_q <= m1_contact_q;
      m2_negx_q    <= m1_negx_q;
      m2_negy_q    <= m1_negy_q;
      m2_cax_q     <= {{3{m1_ax_q[31]}}, m1_ax_q} + {sax_w[33], sax_w};
      m2_cay_q     <= {{3{m1_ay_q[31]}}, m1_ay_q} + {say_w[33], say_w};
      m2_cbx_q     <= {{3{m1_bx_q[31]}}, m1_bx_q} - {sbx_w[33], sbx_w};
      m2_cby_q     <= {{3{m1_by_q[31]}}, m1_by_q} - {sby_w[33], sby_w};
      m2_nmx_q     <= m1_nmx_q;
      m2_nmy_q     <= m1_nmy_q;
      m2_nx_q      <= m1_negx_q ? -$signed({1'b0, m1_nmx_q}) : $signed({1'b0, m1_nmx_q});
      m2_ny_q      <= m1_negy_q ? -$signed({1'b0, m1_nmy_q}) : $signed({1'b0, m1_nmy_q});
    end
  end

  // ---------------- M3: midpoint with saturation, gap vector ----------------
  logic signed [35:0] sumx_w, sumy_w, hx_w, hy_w;
  logic        [31:0] px_w, py_w;

  assign sumx_w = {m2_cax_q[34], m2_cax_q} + {m2_cbx_q[34], m2_cbx_q};
  assign sumy_w = {m2_cay_q[34], m2_cay_q} + {m2_cby_q[34], m2_cby_q};
  assign hx_w   = sumx_w >>> 1;
  assign hy_w   = sumy_w >>> 1;

  always_comb begin
    px_w = hx_w[31:0];
    if (!(&hx_w[35:31] || ~|hx_w[35:31])) begin
      px_w = hx_w[35] ? cpc_pkg::PointMin : cpc_pkg::PointMax;
    end
    py_w = hy_w[31:0];
    if (!(&hy_w[35:31] || ~|hy_w[35:31])) begin
      py_w = hy_w[35] ? cpc_pkg::PointMin : cpc_pkg::PointMax;
    end
  end

  logic               m3_v_q, m3_contact_q, m3_negx_q, m3_negy_q;
  logic signed [35:0] m3_dvx_q, m3_dvy_q;
  logic        [31:0] m3_px_q, m3_py_q;
  logic        [30:0] m3_nmx_q, m3_nmy_q;
  logic signed [31:0] m3_nx_q, m3_ny_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m3_contact_q <= m2_contact_q;
      m3_negx_q    <= m2_negx_q;
      m3_negy_q    <= m2_negy_q;
      m3_dvx_q     <= {m2_cbx_q[34], m2_cbx_q} - {m2_cax_q[34], m2_cax_q};
      m3_dvy_q     <= {m2_cby_q[34], m2_cby_q} - {m2_cay_q[34], m2_cay_q};
      m3_px_q      <= px_w;
      m3_py_q      <= py_w;
      m3_nmx_q     <= m2_nmx_q;
      m3_nmy_q     <= m2_nmy_q;
      m3_nx_q      <= m2_nx_q;
      m3_ny_q      <= m2_ny_q;
    end
  end

  // ---------------- M4: gap times normal, split partial products ----------
  logic [35:0] magx_w, magy_w;
  assign magx_w = m3_dvx_q[35] ? 36'(-m3_dvx_q) : m3_dvx_q;
  assign magy_w = m3_dvy_q[35] ? 36'(-m3_dvy_q) : m3_dvy_q;

  logic               m4_v_q, m4_contact_q, m4_snx_q, m4_sny_q;
  logic        [47:0] m4_plx_q, m4_phx_q, m4_ply_q, m4_phy_q;
  logic        [31:0] m4_px_q, m4_py_q;
  logic signed [31:0] m4_nx_q, m4_ny_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m4_contact_q <= m3_contact_q;
      m4_snx_q     <= m3_dvx_q[35] ^ m3_negx_q;
      m4_sny_q     <= m3_dvy_q[35] ^ m3_negy_q;
      m4_plx_q     <= magx_w[16:0] * m3_nmx_q;
      m4_phx_q     <= magx_w[33:17] * m3_nmx_q;
      m4_ply_q     <= magy_w[16:0] * m3_nmy_q;
      m4_phy_q     <= magy_w[33:17] * m3_nmy_q;
      m4_px_q      <= m3_px_q;
      m4_py_q      <= m3_py_q;
      m4_nx_q      <= m3_nx_q;
      m4_ny_q      <= m3_ny_q;
    end
  end

  // ---------------- M5: combine, round each product ----------------
  logic [64:0] fpx_w, fpy_w;
  logic [34:0] rqx_w, rqy_w;

  assign fpx_w = 65'(m4_plx_q) + (65'(m4_phx_q) << 17);
  assign fpy_w = 65'(m4_ply_q) + (65'(m4_phy_q) << 17);
  assign rqx_w = 35'((fpx_w + 65'(cpc_pkg::Q30Half)) >> cpc_pkg::Q30Shift);
  assign rqy_w = 35'((fpy_w + 65'(cpc_pkg::Q30Half)) >> cpc_pkg::Q30Shift);

  logic               m5_v_q, m5_contact_q;
  logic signed [35:0] m5_sqx_q, m5_sqy_q;
  logic        [31:0] m5_px_q, m5_py_q;
  logic signed [31:0] m5_nx_q, m5_ny_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m5_contact_q <= m4_contact_q;
      m5_sqx_q     <= m4_snx_q ? -$signed({1'b0, rqx_w}) : $signed({1'b0, rqx_w});
      m5_sqy_q     <= m4_sny_q ? -$signed({1'b0, rqy_w}) : $signed({1'b0, rqy_w});
      m5_px_q      <= m4_px_q;
      m5_py_q      <= m4_py_q;
      m5_nx_q      <= m4_nx_q;
      m5_ny_q      <= m4_ny_q;
    end
  end

  // ---------------- M6: separation sum, saturation, output register -------
  logic signed [36:0] sep_w;
  logic        [33:0] sepc_w;

  assign sep_w = {m5_sqx_q[35], m5_sqx_q} + {m5_sqy_q[35], m5_sqy_q};

  always_comb begin
    sepc_w = sep_w[33:0];
    if (!(&sep_w[36:33] || ~|sep_w[36:33])) begin
      sepc_w = sep_w[36] ? cpc_pkg::SepMin : cpc_pkg::SepMax;
    end
  end

  logic               m6_contact_q;
  logic signed [31:0] m6_nx_q, m6_ny_q, m6_px_q, m6_py_q;
  logic signed [33:0] m6_sep_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m6_contact_q <= m5_contact_q;
      m6_nx_q      <= m5_contact_q ? m5_nx_q : '0;
      m6_ny_q      <= m5_contact_q ? m5_ny_q : '0;
      m6_px_q      <= m5_contact_q ? m5_px_q : '0;
      m6_py_q      <= m5_contact_q ? m5_py_q : '0;
      m6_sep_q     <= m5_contact_q ? sepc_w : '0;
    end
  end

  // valid bits for the stages kept in this module
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_v_q <= 1'b0;
      e2_v_q <= 1'b0;
      e3_v_q <= 1'b0;
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
      m4_v_q <= 1'b0;
      m5_v_q <= 1'b0;
      m6_v_q <= 1'b0;
    end else if (adv) begin
      e1_v_q <= in_if.valid;
      e2_v_q <= e1_v_q;
      e3_v_q <= e2_v_q;
      m1_v_q <= dv_v;
      m2_v_q <= m1_v_q;
      m3_v_q <= m2_v_q;
      m4_v_q <= m3_v_q;
      m5_v_q <= m4_v_q;
      m6_v_q <= m5_v_q;
    end
  end

  assign out_if.valid       = m6_v_q;
  assign out_if.has_contact = m6_contact_q;
  assign out_if.normal_x    = m6_nx_q;
  assign out_if.normal_y    = m6_ny_q;
  assign out_if.point_x     = m6_px_q;
  assign out_if.point_y     = m6_py_q;
  assign out_if.separation  = m6_sep_q;

  // ---------------- checks ----------------
  a_no_contact_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.has_contact |->
      (out_if.normal_x == 32'sd0) && (out_if.normal_y == 32'sd0) &&
      (out_if.point_x == 32'sd0) && (out_if.point_y == 32'sd0) &&
      (out_if.separation == 34'sd0))
    else $error("no-contact result carries nonzero fields");

  a_normal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |->
      (out_if.normal_x <= 32'sd1073741824) && (out_if.normal_x >= -32'sd1073741824) &&
      (out_if.normal_y <= 32'sd1073741824) && (out_if.normal_y >= -32'sd1073741824))
    else $error("normal component outside unit range");

  a_stall_only_on_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> out_if.valid && !out_if.ready)
    else $error("input held off without a stalled result");

endmodule
`default_nettype wire

[rtl/core/cpc_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_isqrt
// Pipelined integer square root, one result bit per stage (32 stages).
// ----------------------------------------------------------------------------
module cpc_isqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [63:0]         rad_i,
  input  cpc_pkg::cpc_side_t  side_i,
  output logic                valid_o,
  output logic [31:0]         root_o,
  output cpc_pkg::cpc_side_t  side_o
);

  localparam int unsigned Steps = 32;

  logic               v_q    [Steps];
  logic [33:0]        rem_q  [Steps];
  logic [31:0]        root_q [Steps];
  logic [63:0]        rad_q  [Steps];
  cpc_pkg::cpc_side_t side_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic               v_in;
    logic [33:0]        rem_in;
    logic [31:0]        root_in;
    logic [63:0]        rad_in;
    cpc_pkg::cpc_side_t side_in;
    logic [35:0]        cur;
    logic [35:0]        trial;
    logic               fit;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down the next radicand digit pair and try 4*root+1
    assign cur   = {rem_in, rad_in[63-2*k -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign fit   = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= fit ? 34'(cur - trial) : cur[33:0];
        root_q[k] <= {root_in[30:0], fit};
        rad_q[k]  <= rad_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign root_o  = root_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule
`default_nettype wire

[rtl/core/cpc_ndiv.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_ndiv
// Pipelined normalize divider: rounded (m * 2^30) / L for both axes,
// one setup stage and one quotient bit per stage after it.
// ----------------------------------------------------------------------------
module cpc_ndiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [31:0]         len_i,
  input  cpc_pkg::cpc_side_t  side_i,
  output logic                valid_o,
  output logic [30:0]         qx_o,
  output logic [30:0]         qy_o,
  output logic                lzero_o,
  output cpc_pkg::cpc_side_t  side_o
);

  localparam int unsigned QBits = 31;

  // setup stage: numerators with the rounding half of L folded in
  logic               s_v_q;
  logic [61:0]        s_nx_q, s_ny_q;
  logic [31:0]        s_len_q;
  cpc_pkg::cpc_side_t s_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q <= 1'b0;
    end else if (en_i) begin
      s_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_len_q  <= len_i;
      s_side_q <= side_i;
      s_nx_q   <= {1'b0, side_i.mx, 30'd0} + {31'd0, len_i[31:1]};
      s_ny_q   <= {1'b0, side_i.my, 30'd0} + {31'd0, len_i[31:1]};
    end
  end

  logic               v_q    [QBits];
  logic [61:0]        nx_q   [QBits];
  logic [61:0]        ny_q   [QBits];
  logic [31:0]        rx_q   [QBits];
  logic [31:0]        ry_q   [QBits];
  logic [30:0]        qx_q   [QBits];
  logic [30:0]        qy_q   [QBits];
  logic [31:0]        len_q  [QBits];
  cpc_pkg::cpc_side_t side_q [QBits];

  for (genvar k = 0; k < QBits; k++) begin : g_step
    logic               v_in;
    logic [61:0]        nx_in, ny_in;
    logic [31:0]        rx_in, ry_in;
    logic [30:0]        qx_in, qy_in;
    logic [31:0]        len_in;
    cpc_pkg::cpc_side_t side_in;
    logic [32:0]        curx, cury;
    logic               fitx, fity;

    if (k == 0) begin : g_first
      assign v_in    = s_v_q;
      assign nx_in   = s_nx_q;
      assign ny_in   = s_ny_q;
      assign rx_in   = {1'b0, s_nx_q[61:31]};
      assign ry_in   = {1'b0, s_ny_q[61:31]};
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign len_in  = s_len_q;
      assign side_in = s_side_q;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign nx_in   = nx_q[k-1];
      assign ny_in   = ny_q[k-1];
      assign rx_in   = rx_q[k-1];
      assign ry_in   = ry_q[k-1];
      assign qx_in   = qx_q[k-1];
      assign qy_in   = qy_q[k-1];
      assign len_in  = len_q[k-1];
      assign side_in = side_q[k-1];
    end

    // shift in the next numerator bit, subtract L when it fits
    assign curx = {rx_in, nx_in[30-k]};
    assign cury = {ry_in, ny_in[30-k]};
    assign fitx = (curx >= {1'b0, len_in});
    assign fity = (cury >= {1'b0, len_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nx_q[k]   <= nx_in;
        ny_q[k]   <= ny_in;
        rx_q[k]   <= fitx ? 32'(curx - {1'b0, len_in}) : curx[31:0];
        ry_q[k]   <= fity ? 32'(cury - {1'b0, len_in}) : cury[31:0];
        qx_q[k]   <= {qx_in[29:0], fitx};
        qy_q[k]   <= {qy_in[29:0], fity};
        len_q[k]  <= len_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[QBits-1];
  assign qx_o    = qx_q[QBits-1];
  assign qy_o    = qy_q[QBits-1];
  assign lzero_o = (len_q[QBits-1] == 32'd0);
  assign side_o  = side_q[QBits-1];

endmodule
`default_nettype wire
